/* design/dafilt_pkg.sv */
// ---------------------------------------------------------------------------
// dafilt_pkg
// Shared widths, register codes and the sine table generator for the arena
// detection filter.
// ---------------------------------------------------------------------------
package dafilt_pkg;

    localparam int ANGLE_BITS_DEFAULT = 16;

    localparam int HEADING_W   = 16;
    localparam int POS_W       = 13;
    localparam int DIST_W      = 12;
    localparam int SIDE_W      = 2;
    localparam int OFFSET_W    = 10;
    localparam int BOUND_W     = 13;
    localparam int OUT_W       = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // Q0.15 sine magnitude, 0..32767
    localparam int SINE_W    = 15;
    localparam int SINE_FRAC = 15;

    // pi/2 in Q30
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    // one quarter turn is 2**14 binary angle units
    localparam int QUARTER_TURN_BITS = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SENSOR_OFFSET = 3'd0,
        REG_BOUND_X_LOW   = 3'd1,
        REG_BOUND_X_HIGH  = 3'd2,
        REG_BOUND_Y_LOW   = 3'd3,
        REG_BOUND_Y_HIGH  = 3'd4
    } cfg_reg_t;

    localparam logic [OFFSET_W-1:0] SENSOR_OFFSET_RST = 10'd110;
    localparam logic [BOUND_W-1:0]  BOUND_X_LOW_RST   = 13'd150;
    localparam logic [BOUND_W-1:0]  BOUND_X_HIGH_RST  = 13'd1850;
    localparam logic [BOUND_W-1:0]  BOUND_Y_LOW_RST   = 13'd150;
    localparam logic [BOUND_W-1:0]  BOUND_Y_HIGH_RST  = 13'd2850;

    // Quotient of two non-negative values by shift and subtract; only used
    // while the sine table is filled, never in the datapath.
    function automatic longint table_udiv(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // First-quadrant sine, r in 0..16384 (full 16-bit binary angle units).
    // Q30 Taylor series up to x^15, rounded to Q0.15 and clamped.
    function automatic logic [SINE_W-1:0] quarter_sine(input longint r);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint q;
        x    = (r * HALF_PI_Q30) >>> QUARTER_TURN_BITS;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = table_udiv((term * x2) >>> 30,
                              longint'((2 * k) * (2 * k + 1)));
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        q = (sum + 64'sd16384) >>> 15;
        if (q > 64'sd32767)
            q = 64'sd32767;
        return q[SINE_W-1:0];
    endfunction

endpackage

/* design/detection_arena_filter_top.sv */
// ---------------------------------------------------------------------------
// detection_arena_filter_top
// Projects a range-sensor detection into field coordinates and flags whether
// it lies strictly inside a configurable rectangle.
// ---------------------------------------------------------------------------
// Usage: one transaction per clock is accepted while out_ready is high, and one
// result per input is returned, in order. There are three register stages
// (stage 1, stage 2 and the output register), and out_valid rises when the
// transaction reaches the output register; at most three transactions are in
// flight. The pipeline is: (1) heading quantized to ANGLE_BITS and the quarter-
// wave sine ROM read on two ports (sine and cosine at once), (2) four small
// multiplies (offset and distance by sine and cosine), (3) round to mm, add
// to the pose, saturate to 15 bits and compare against the bounds. The ROM
// holds 2**(ANGLE_BITS-2)+1 entries built at time zero, so it needs no
// loading after reset. Stalls propagate backward stage by stage, so a full
// pipeline keeps accepting as long as out_ready is high. Registers are
// written through cfg_wr_en/cfg_index/cfg_data and should only change while
// no transaction is in flight; unknown indexes are ignored. An invalid side
// code (binary 10) is treated as centre.
// ---------------------------------------------------------------------------
module detection_arena_filter_top #(
    parameter int ANGLE_BITS = dafilt_pkg::ANGLE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [dafilt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dafilt_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [dafilt_pkg::POS_W-1:0]  robot_x_mm,
    input  logic signed [dafilt_pkg::POS_W-1:0]  robot_y_mm,
    input  logic [dafilt_pkg::HEADING_W-1:0]     robot_heading,
    input  logic [dafilt_pkg::DIST_W-1:0]        detect_distance_mm,
    input  logic signed [dafilt_pkg::SIDE_W-1:0] sensor_side,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 inside_area,
    output logic signed [dafilt_pkg::OUT_W-1:0]  object_x_mm,
    output logic signed [dafilt_pkg::OUT_W-1:0]  object_y_mm
);
    import dafilt_pkg::*;

    localparam int QUARTER_BITS = ANGLE_BITS - 2;
    localparam int ADDR_W       = QUARTER_BITS + 1;
    localparam int SINE_S_W     = SINE_W + 1;            // signed sine
    localparam int OFF_PROD_W   = OFFSET_W + 1 + SINE_S_W;
    localparam int DIST_PROD_W  = DIST_W + 1 + SINE_S_W;
    localparam int OFF_RND_W    = OFF_PROD_W - SINE_FRAC;
    localparam int DIST_RND_W   = DIST_PROD_W - SINE_FRAC;
    localparam int SUM_W        = OUT_W + 1;

    localparam logic [ADDR_W-1:0] QUARTER_SPAN = {1'b1, {QUARTER_BITS{1'b0}}};
    localparam logic signed [OFF_PROD_W-1:0] OFF_HALF =
        OFF_PROD_W'(1 << (SINE_FRAC - 1));
    localparam logic signed [DIST_PROD_W-1:0] DIST_HALF =
        DIST_PROD_W'(1 << (SINE_FRAC - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (OUT_W - 1)));

    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'b01;
    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'b11;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [OFFSET_W-1:0] sensor_offset_reg;
    logic [BOUND_W-1:0]  bound_x_low_reg;
    logic [BOUND_W-1:0]  bound_x_high_reg;
    logic [BOUND_W-1:0]  bound_y_low_reg;
    logic [BOUND_W-1:0]  bound_y_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_offset_reg <= SENSOR_OFFSET_RST;
            bound_x_low_reg   <= BOUND_X_LOW_RST;
            bound_x_high_reg  <= BOUND_X_HIGH_RST;
            bound_y_low_reg   <= BOUND_Y_LOW_RST;
            bound_y_high_reg  <= BOUND_Y_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SENSOR_OFFSET: sensor_offset_reg <= cfg_data[OFFSET_W-1:0];
                REG_BOUND_X_LOW:   bound_x_low_reg   <= cfg_data[BOUND_W-1:0];
                REG_BOUND_X_HIGH:  bound_x_high_reg  <= cfg_data[BOUND_W-1:0];
                REG_BOUND_Y_LOW:   bound_y_low_reg   <= cfg_data[BOUND_W-1:0];
                REG_BOUND_Y_HIGH:  bound_y_high_reg  <= cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Handshake: each stage loads when empty or when its successor drains
    // -----------------------------------------------------------------------
    logic s1_vld_reg, s1_vld_next;
    logic s2_vld_reg, s2_vld_next;
    logic out_vld_reg, out_vld_next;
    logic out_free, s2_ready, s1_load, s2_load, out_load;

    assign out_free = !out_vld_reg || out_ready;
    assign out_load = s2_vld_reg && out_free;
    assign s2_ready = !s2_vld_reg || out_free;
    assign s2_load  = s1_vld_reg && s2_ready;
    assign in_ready = !s1_vld_reg || s2_ready;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_vld_next  = s1_load  ? 1'b1 : (s2_load  ? 1'b0 : s1_vld_reg);
        s2_vld_next  = s2_load  ? 1'b1 : (out_load ? 1'b0 : s2_vld_reg);
        out_vld_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: quantize heading, fold to first quadrant, read ROM
    // -----------------------------------------------------------------------
    logic [ANGLE_BITS-1:0]   heading_q;
    logic [1:0]              sin_quad, cos_quad;
    logic [QUARTER_BITS-1:0] quad_rem;
    logic [ADDR_W-1:0]       sin_addr, cos_addr;
    logic [SINE_W-1:0]       sin_mag, cos_mag;

    assign heading_q = robot_heading[HEADING_W-1 -: ANGLE_BITS];
    assign sin_quad  = heading_q[ANGLE_BITS-1 -: 2];
    assign cos_quad  = sin_quad + 2'd1;     // cosine = sine a quarter turn on
    assign quad_rem  = heading_q[QUARTER_BITS-1:0];
    assign sin_addr  = sin_quad[0] ? (QUARTER_SPAN - {1'b0, quad_rem}) : {1'b0, quad_rem};
    assign cos_addr  = cos_quad[0] ? (QUARTER_SPAN - {1'b0, quad_rem}) : {1'b0, quad_rem};

    dafilt_sine_rom #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sine_rom (
        .clk       (clk),
        .rd_en     (s1_load),
        .rd_addr_a (sin_addr),
        .rd_addr_b (cos_addr),
        .rd_data_a (sin_mag),
        .rd_data_b (cos_mag)
    );

    logic signed [POS_W-1:0]  s1_px_reg, s1_py_reg;
    logic [DIST_W-1:0]        s1_dist_reg;
    logic [SIDE_W-1:0]        s1_side_reg;
    logic                     s1_sin_neg_reg, s1_cos_neg_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_px_reg      <= robot_x_mm;
            s1_py_reg      <= robot_y_mm;
            s1_dist_reg    <= detect_distance_mm;
            s1_side_reg    <= sensor_side;
            s1_sin_neg_reg <= sin_quad[1];
            s1_cos_neg_reg <= cos_quad[1];
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: apply sign, four products
    // -----------------------------------------------------------------------
    logic signed [SINE_S_W-1:0]    sin_s, cos_s;
    logic signed [OFF_PROD_W-1:0]  off_sin, off_cos;
    logic signed [DIST_PROD_W-1:0] dist_sin, dist_cos;

    assign sin_s = s1_sin_neg_reg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign cos_s = s1_cos_neg_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

    assign off_sin  = $signed({1'b0, sensor_offset_reg}) * sin_s;
    assign off_cos  = $signed({1'b0, sensor_offset_reg}) * cos_s;
    assign dist_sin = $signed({1'b0, s1_dist_reg}) * sin_s;
    assign dist_cos = $signed({1'b0, s1_dist_reg}) * cos_s;

    logic signed [POS_W-1:0]       s2_px_reg, s2_py_reg;
    logic [SIDE_W-1:0]             s2_side_reg;
    logic signed [OFF_PROD_W-1:0]  s2_off_sin_reg, s2_off_cos_reg;
    logic signed [DIST_PROD_W-1:0] s2_dist_sin_reg, s2_dist_cos_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_px_reg       <= s1_px_reg;
            s2_py_reg       <= s1_py_reg;
            s2_side_reg     <= s1_side_reg;
            s2_off_sin_reg  <= off_sin;
            s2_off_cos_reg  <= off_cos;
            s2_dist_sin_reg <= dist_sin;
            s2_dist_cos_reg <= dist_cos;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3: round (halves up), sum, saturate, area test
    // -----------------------------------------------------------------------
    logic signed [OFF_PROD_W-1:0]  off_sin_biased, off_cos_biased;
    logic signed [DIST_PROD_W-1:0] dist_sin_biased, dist_cos_biased;
    logic signed [OFF_RND_W-1:0]   rnd_off_sin, rnd_off_cos;
    logic signed [DIST_RND_W-1:0]  rnd_dist_sin, rnd_dist_cos;
    logic signed [OFF_RND_W-1:0]   side_x, side_y;
    logic signed [SUM_W-1:0]       x_sum, y_sum;
    logic signed [OUT_W-1:0]       x_sat, y_sat;
    logic                          in_area;

    // floor((p + half) / 2^15) for either sign
    assign off_sin_biased  = s2_off_sin_reg + OFF_HALF;
    assign off_cos_biased  = s2_off_cos_reg + OFF_HALF;
    assign dist_sin_biased = s2_dist_sin_reg + DIST_HALF;
    assign dist_cos_biased = s2_dist_cos_reg + DIST_HALF;

    assign rnd_off_sin  = off_sin_biased[OFF_PROD_W-1:SINE_FRAC];
    assign rnd_off_cos  = off_cos_biased[OFF_PROD_W-1:SINE_FRAC];
    assign rnd_dist_sin = dist_sin_biased[DIST_PROD_W-1:SINE_FRAC];
    assign rnd_dist_cos = dist_cos_biased[DIST_PROD_W-1:SINE_FRAC];

    always_comb
    begin
        case (s2_side_reg)
            SIDE_RIGHT:
            begin
                side_x = rnd_off_sin;
                side_y = -rnd_off_cos;
            end
            SIDE_LEFT:
            begin
                side_x = -rnd_off_sin;
                side_y = rnd_off_cos;
            end
            default:        // centre, and the unused code
            begin
                side_x = '0;
                side_y = '0;
            end
        endcase
    end

    assign x_sum = SUM_W'(s2_px_reg) + SUM_W'(side_x) + SUM_W'(rnd_dist_cos);
    assign y_sum = SUM_W'(s2_py_reg) + SUM_W'(side_y) + SUM_W'(rnd_dist_sin);

    always_comb
    begin
        if (x_sum > SAT_HI)
            x_sat = SAT_HI[OUT_W-1:0];
        else if (x_sum < SAT_LO)
            x_sat = SAT_LO[OUT_W-1:0];
        else
            x_sat = x_sum[OUT_W-1:0];

        if (y_sum > SAT_HI)
            y_sat = SAT_HI[OUT_W-1:0];
        else if (y_sum < SAT_LO)
            y_sat = SAT_LO[OUT_W-1:0];
        else
            y_sat = y_sum[OUT_W-1:0];
    end

    assign in_area = (x_sat > $signed({2'b00, bound_x_low_reg}))  &&
                     (x_sat < $signed({2'b00, bound_x_high_reg})) &&
                     (y_sat > $signed({2'b00, bound_y_low_reg}))  &&
                     (y_sat < $signed({2'b00, bound_y_high_reg}));

    logic                    inside_reg;
    logic signed [OUT_W-1:0] obj_x_reg, obj_y_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            inside_reg <= in_area;
            obj_x_reg  <= x_sat;
            obj_y_reg  <= y_sat;
        end
    end

    assign out_valid   = out_vld_reg;
    assign inside_area = inside_reg;
    assign object_x_mm = obj_x_reg;
    assign object_y_mm = obj_y_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    // an accepted transaction always occupies stage 1 on the next cycle
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_vld_reg)
        else $error("accepted transaction lost at stage 1");

    // with every stage full and the output stalled, input must back off
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && s2_vld_reg && out_vld_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while pipeline is full");

    // a stage-2 transaction moving out produces a valid result next cycle
    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("result dropped between stage 2 and output");

    // the area flag agrees with the reported coordinates
    a_inside_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_area) |->
            (object_x_mm > $signed({2'b00, bound_x_low_reg})) &&
            (object_x_mm < $signed({2'b00, bound_x_high_reg})) &&
            (object_y_mm > $signed({2'b00, bound_y_low_reg})) &&
            (object_y_mm < $signed({2'b00, bound_y_high_reg})))
        else $error("inside_area set for a point outside the bounds");

endmodule

/* design/dafilt_sine_rom.sv */
// ---------------------------------------------------------------------------
// dafilt_sine_rom
// Quarter-wave sine ROM with two registered read ports (sine and cosine).
// ---------------------------------------------------------------------------
module dafilt_sine_rom #(
    parameter int ANGLE_BITS = dafilt_pkg::ANGLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [ANGLE_BITS-2:0]         rd_addr_a,
    input  logic [ANGLE_BITS-2:0]         rd_addr_b,
    output logic [dafilt_pkg::SINE_W-1:0] rd_data_a,
    output logic [dafilt_pkg::SINE_W-1:0] rd_data_b
);
    import dafilt_pkg::*;

    localparam int QUARTER_BITS = ANGLE_BITS - 2;
    localparam int DEPTH        = (1 << QUARTER_BITS) + 1;
    localparam int STEP_SHIFT   = HEADING_W - ANGLE_BITS;

    logic [SINE_W-1:0] sine_rom [DEPTH];

    // table contents are fixed; filled once at time zero
    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            sine_rom[i] = quarter_sine(longint'(i) << STEP_SHIFT);
        end
    end

    logic [SINE_W-1:0] rd_data_a_reg;
    logic [SINE_W-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= sine_rom[rd_addr_a];
            rd_data_b_reg <= sine_rom[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - arena detection filter testbench
// Drives pose/range transactions into detection_arena_filter_top and checks
// every result against an in-bench projection of the detection into field
// coordinates. Covers the reset register values, field extremes, register
// extremes (strict area edges, open and empty areas, offset masking and
// unknown indexes), random traffic over several register settings with
// random idling on both sides, and a long output hold-off.
// ---------------------------------------------------------------------------
module tb;
    import dafilt_pkg::*;

    localparam int ANGLE_W = 16;

    // pi/2 in Q30 and one quarter turn in binary angle units
    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint QTR_TURN    = 64'sd16384;
    localparam longint OBJ_MAX     = 64'sd16383;
    localparam longint OBJ_MIN     = -64'sd16384;

    localparam int SETTLE_CYCLES = 8;     // pipeline is 3 deep, plus margin
    localparam int STALL_LIMIT   = 5000;  // cycles with no transaction at all
    localparam int HOLD_OFF_LEN  = 150;

    localparam logic [HEADING_W-1:0] HDG_EAST  = 16'd0;
    localparam logic [HEADING_W-1:0] HDG_NORTH = 16'd16384;
    localparam logic [HEADING_W-1:0] HDG_WEST  = 16'd32768;
    localparam logic [HEADING_W-1:0] HDG_SOUTH = 16'd49152;

    localparam logic signed [SIDE_W-1:0] SIDE_LEFT   = -2'sd1;
    localparam logic signed [SIDE_W-1:0] SIDE_CENTRE = 2'sd0;
    localparam logic signed [SIDE_W-1:0] SIDE_RIGHT  = 2'sd1;
    localparam logic signed [SIDE_W-1:0] SIDE_BAD    = -2'sd2;  // binary 10

    typedef struct {
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic [HEADING_W-1:0]     hdg;
        logic [DIST_W-1:0]        range_mm;
        logic signed [SIDE_W-1:0] side;
    } pose_sample_t;

    typedef struct {
        logic                    in_area;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } detection_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [POS_W-1:0]   robot_x_mm;
    logic signed [POS_W-1:0]   robot_y_mm;
    logic [HEADING_W-1:0]      robot_heading;
    logic [DIST_W-1:0]         detect_distance_mm;
    logic signed [SIDE_W-1:0]  sensor_side;
    logic                      out_valid;
    logic                      out_ready;
    logic                      inside_area;
    logic signed [OUT_W-1:0]   object_x_mm;
    logic signed [OUT_W-1:0]   object_y_mm;

    // bench copy of the register file
    logic [OFFSET_W-1:0] shadow_offset;
    logic [BOUND_W-1:0]  shadow_x_low;
    logic [BOUND_W-1:0]  shadow_x_high;
    logic [BOUND_W-1:0]  shadow_y_low;
    logic [BOUND_W-1:0]  shadow_y_high;

    // projected detections waiting for their result transaction, oldest first
    detection_t pending_detections[$];
    detection_t want;

    int error_count  = 0;
    int quiet_cycles = 0;
    int hold_cycles  = 0;   // set by a test, consumed by the receiver
    int hold_n;
    bit tx_gaps_on   = 1'b0;
    bit rx_stalls_on = 1'b0;

    detection_arena_filter_top #(
        .ANGLE_BITS(ANGLE_W)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .robot_x_mm         (robot_x_mm),
        .robot_y_mm         (robot_y_mm),
        .robot_heading      (robot_heading),
        .detect_distance_mm (detect_distance_mm),
        .sensor_side        (sensor_side),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .inside_area        (inside_area),
        .object_x_mm        (object_x_mm),
        .object_y_mm        (object_y_mm)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Projection of one detection
    // -----------------------------------------------------------------------

    // sine over the first quadrant, r in 0..16384, as a Q0.15 magnitude.
    // Q30 Taylor series through x^15, truncating divides, then round.
    function automatic longint sine_first_quadrant(longint r);
        longint ang;
        longint ang2;
        longint term_v;
        longint acc;
        longint q;
        ang    = (r * PI_HALF_Q30) / QTR_TURN;
        ang2   = (ang * ang) >>> 30;
        term_v = ang;
        acc    = ang;
        for (int k = 1; k <= 7; k++)
        begin
            term_v = ((term_v * ang2) >>> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term_v;
            else
                acc = acc + term_v;
        end
        if (acc < 0)
            acc = 0;
        q = (acc + 64'sd16384) >>> 15;
        return (q > 64'sd32767) ? 64'sd32767 : q;
    endfunction

    // full-circle sine from the heading, low bits dropped to the table size
    function automatic longint sine_lookup(logic [HEADING_W-1:0] a);
        logic [HEADING_W-1:0] am;
        longint               mag;
        am = a & ({HEADING_W{1'b1}} << (HEADING_W - ANGLE_W));
        if (am[14])
            mag = sine_first_quadrant(QTR_TURN - longint'(am[13:0]));
        else
            mag = sine_first_quadrant(longint'(am[13:0]));
        return am[15] ? -mag : mag;
    endfunction

    // Q15 product to mm, halves away from minus infinity
    function automatic longint round_to_mm(longint p);
        if (p >= 0)
            return (p + 64'sd16384) >>> 15;
        return -((-p + 64'sd16383) >>> 15);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > OBJ_MAX)
            return OBJ_MAX;
        if (v < OBJ_MIN)
            return OBJ_MIN;
        return v;
    endfunction

    function automatic detection_t project_detection(pose_sample_t s);
        detection_t             r;
        logic [HEADING_W-1:0]   hq;
        longint                 lat;
        longint                 off;
        longint                 rng;
        longint                 sn;
        longint                 cs;
        longint                 xv;
        longint                 yv;
        lat = longint'(s.side);
        if (lat < -1)
            lat = 0;            // invalid side code acts as centre
        off  = longint'(shadow_offset);
        rng  = longint'(s.range_mm);
        hq   = s.hdg + HDG_NORTH;
        sn   = sine_lookup(s.hdg);
        cs   = sine_lookup(hq);
        xv = longint'(s.px) + lat * round_to_mm(off * sn) + round_to_mm(rng * cs);
        yv = longint'(s.py) - lat * round_to_mm(off * cs) + round_to_mm(rng * sn);
        xv = clamp_coord(xv);
        yv = clamp_coord(yv);
        r.in_area = (xv > longint'(shadow_x_low)) && (xv < longint'(shadow_x_high)) &&
                    (yv > longint'(shadow_y_low)) && (yv < longint'(shadow_y_high));
        r.x = xv[OUT_W-1:0];
        r.y = yv[OUT_W-1:0];
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    function automatic pose_sample_t mk_sample(int px, int py, logic [HEADING_W-1:0] hdg,
                                               int range_mm, logic signed [SIDE_W-1:0] side);
        pose_sample_t s;
        s.px       = POS_W'(px);
        s.py       = POS_W'(py);
        s.hdg      = hdg;
        s.range_mm = DIST_W'(range_mm);
        s.side     = side;
        return s;
    endfunction

    // Mostly poses on the field so the area test sees both outcomes; some
    // fully random poses, headings near the axes, and distance extremes.
    function automatic pose_sample_t rand_sample();
        pose_sample_t s;
        logic [31:0]  rnd;
        int           pick;
        rnd = $urandom;
        if ($urandom_range(0, 3) == 0)
            s.px = rnd[12:0];
        else
            s.px = POS_W'($urandom_range(0, 3000));
        if ($urandom_range(0, 3) == 0)
            s.py = rnd[25:13];
        else
            s.py = POS_W'($urandom_range(0, 3000));
        rnd = $urandom;
        if ($urandom_range(0, 4) == 0)
            s.hdg = {rnd[1:0], 14'd0} + HEADING_W'($urandom_range(0, 2)) - 16'd1;
        else
            s.hdg = rnd[15:0];
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.range_mm = '0;
        else if (pick == 1)
            s.range_mm = '1;
        else
            s.range_mm = rnd[27:16];
        pick = $urandom_range(0, 9);
        if (pick < 3)
            s.side = SIDE_LEFT;
        else if (pick < 6)
            s.side = SIDE_CENTRE;
        else if (pick < 9)
            s.side = SIDE_RIGHT;
        else
            s.side = SIDE_BAD;
        return s;
    endfunction

    // Offer one transaction; returns in the step of the accepting edge with
    // in_valid still high, so back-to-back calls keep valid asserted.
    task automatic send_sample(pose_sample_t s);
        if (tx_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid           <= 1'b1;
        robot_x_mm         <= s.px;
        robot_y_mm         <= s.py;
        robot_heading      <= s.hdg;
        detect_distance_mm <= s.range_mm;
        sensor_side        <= s.side;
        do
            @(posedge clk);
        while (!in_ready);
        pending_detections.push_back(project_detection(s));
    endtask

    // Register writes only happen with the pipeline empty.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_SENSOR_OFFSET: shadow_offset = val[OFFSET_W-1:0];
            REG_BOUND_X_LOW:   shadow_x_low  = val;
            REG_BOUND_X_HIGH:  shadow_x_high = val;
            REG_BOUND_Y_LOW:   shadow_y_low  = val;
            REG_BOUND_Y_HIGH:  shadow_y_high = val;
            default:           ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait for every expected result, then let the
    // pipeline settle before anything touches the registers.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_detections.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Registers untouched since reset: 110 mm offset, 150..1850 x 150..2850.
    task automatic test_reset_defaults();
        send_sample(mk_sample(1000, 1000, HDG_EAST, 500, SIDE_CENTRE));
        send_sample(mk_sample(1000, 1000, HDG_NORTH, 500, SIDE_RIGHT));
        send_sample(mk_sample(100, 100, HDG_EAST, 10, SIDE_LEFT));
        drain_results();
    endtask

    // Pose, heading and distance at their limits, all four side codes.
    task automatic test_field_extremes();
        send_sample(mk_sample(-4096, -4096, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(4095, 4095, 16'hFFFF, 4095, SIDE_RIGHT));
        send_sample(mk_sample(-4096, 4095, HDG_NORTH, 4095, SIDE_LEFT));
        send_sample(mk_sample(4095, -4096, HDG_WEST, 4095, SIDE_RIGHT));
        send_sample(mk_sample(0, 0, HDG_SOUTH, 4095, SIDE_LEFT));
        send_sample(mk_sample(1000, 1500, 16'd8192, 2000, SIDE_BAD));
        send_sample(mk_sample(1000, 1500, 16'd8192, 2000, SIDE_LEFT));
        send_sample(mk_sample(500, 500, 16'd1, 4095, SIDE_CENTRE));
        send_sample(mk_sample(500, 500, 16'd16383, 4095, SIDE_RIGHT));
        send_sample(mk_sample(500, 500, 16'h7FFF, 1234, SIDE_BAD));
        drain_results();
    endtask

    task automatic test_register_extremes();
        // strict edges: points on each bound are outside, one mm in is inside
        write_reg(REG_BOUND_X_LOW, 13'd100);
        write_reg(REG_BOUND_X_HIGH, 13'd200);
        write_reg(REG_BOUND_Y_LOW, 13'd100);
        write_reg(REG_BOUND_Y_HIGH, 13'd200);
        send_sample(mk_sample(100, 150, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(101, 150, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(199, 150, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(200, 150, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(150, 100, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(150, 101, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(150, 199, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(150, 200, HDG_EAST, 0, SIDE_CENTRE));
        drain_results();

        // widest offset (upper data bits must be dropped), fully open area
        write_reg(REG_SENSOR_OFFSET, '1);
        write_reg(REG_BOUND_X_LOW, '0);
        write_reg(REG_BOUND_X_HIGH, '1);
        write_reg(REG_BOUND_Y_LOW, '0);
        write_reg(REG_BOUND_Y_HIGH, '1);
        send_sample(mk_sample(2000, 2000, 16'd8192, 300, SIDE_RIGHT));
        send_sample(mk_sample(1, 1, HDG_EAST, 0, SIDE_CENTRE));
        send_sample(mk_sample(0, 5, HDG_EAST, 0, SIDE_CENTRE));
        drain_results();

        // no offset, empty area (low above high)
        write_reg(REG_SENSOR_OFFSET, '0);
        write_reg(REG_BOUND_X_LOW, '1);
        write_reg(REG_BOUND_X_HIGH, '0);
        send_sample(mk_sample(1000, 1000, HDG_NORTH, 100, SIDE_LEFT));
        drain_results();

        // writes to indexes past the last register must change nothing
        for (int i = int'(REG_BOUND_Y_HIGH) + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), '1);
        send_sample(mk_sample(1000, 1000, HDG_NORTH, 100, SIDE_RIGHT));
        drain_results();
    endtask

    // Random transactions over several register settings; idling differs
    // from phase to phase so some stretches run with no gaps at all.
    task automatic test_random_traffic();
        int lo;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_SENSOR_OFFSET, CFG_DATA_W'($urandom));
            lo = $urandom_range(0, 2500);
            write_reg(REG_BOUND_X_LOW, CFG_DATA_W'(lo));
            write_reg(REG_BOUND_X_HIGH, CFG_DATA_W'(lo + $urandom_range(0, 5000)));
            lo = $urandom_range(0, 2500);
            write_reg(REG_BOUND_Y_LOW, CFG_DATA_W'(lo));
            write_reg(REG_BOUND_Y_HIGH, CFG_DATA_W'(lo + $urandom_range(0, 5000)));
            tx_gaps_on   = (phase % 2 == 0);
            rx_stalls_on = (phase != 3);
            repeat (70) send_sample(rand_sample());
            drain_results();
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the
    // input while the sender keeps offering; then the sender waits it out.
    task automatic test_output_backpressure();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_cycles  = HOLD_OFF_LEN;
        repeat (40) send_sample(rand_sample());
        drain_results();
    endtask

    // last stretch at full rate, no idling on either side
    task automatic test_quiet_finish();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (40) send_sample(rand_sample());
    endtask

    // -----------------------------------------------------------------------
    // Receiver: random stall bursts, or one long hold-off when a test asks
    // -----------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_n      = hold_cycles;
                hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (hold_n) @(posedge clk);
            end
            else if (rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Result checker: every result transaction against the oldest projection
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_detections.size() == 0)
            begin
                $display("%0t: unexpected result inside_area=%0b x=%0d y=%0d",
                         $time, inside_area, object_x_mm, object_y_mm);
                error_count++;
            end
            else
            begin
                want = pending_detections.pop_front();
                if (inside_area !== want.in_area)
                begin
                    $display("%0t: inside_area expected %0b actual %0b",
                             $time, want.in_area, inside_area);
                    error_count++;
                end
                if (object_x_mm !== want.x)
                begin
                    $display("%0t: object_x_mm expected %0d actual %0d",
                             $time, want.x, object_x_mm);
                    error_count++;
                end
                if (object_y_mm !== want.y)
                begin
                    $display("%0t: object_y_mm expected %0d actual %0d",
                             $time, want.y, object_y_mm);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        robot_x_mm         = '0;
        robot_y_mm         = '0;
        robot_heading      = '0;
        detect_distance_mm = '0;
        sensor_side        = '0;
        shadow_offset      = SENSOR_OFFSET_RST;
        shadow_x_low       = BOUND_X_LOW_RST;
        shadow_x_high      = BOUND_X_HIGH_RST;
        shadow_y_low       = BOUND_Y_LOW_RST;
        shadow_y_high      = BOUND_Y_HIGH_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_quiet_finish();
        drain_results();

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
